[design/tsit_pkg.sv]
// Shared types and constants for the time series interpolation table.
package tsit_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned DEPTH   = 1024;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_INDEX  = 2'd2,
        OP_SKEW   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [WORD_W-1:0]    sample_time;
        logic [WORD_W-1:0]    sample_value;
        logic                 interpolate;
        logic [INDEX_W-1:0]   entry_index;
        logic [WORD_W-1:0]    skew_amount;
    } t_cmd;

    typedef struct packed {
        logic                 accepted;
        logic [WORD_W-1:0]    result_value;
        logic [WORD_W-1:0]    result_time;
        logic [COUNT_W-1:0]   entry_count;
        logic [WORD_W-1:0]    min_value;
        logic [WORD_W-1:0]    max_value;
        logic [WORD_W-1:0]    first_time;
        logic [WORD_W-1:0]    last_time;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VAL_RD,
        ST_VAL_USE,
        ST_IDX_RD,
        ST_IDX_USE,
        ST_SEARCH_RD,
        ST_SEARCH_USE,
        ST_LO_RD,
        ST_LO_USE,
        ST_HI_RD,
        ST_HI_USE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } t_state;

endpackage

[design/tsit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsit_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tsit_front.sv]
// Front end: accepts items, decodes the operation and queues them for the back end.
module tsit_front import tsit_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_mode,
    input  logic [WORD_W-1:0]   i_sample_time,
    input  logic [WORD_W-1:0]   i_sample_value,
    input  logic                i_interpolate,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic [WORD_W-1:0]   i_skew_amount,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_cmd_ready
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_cmd       w_cmd;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_cmd.op           = t_op'(i_mode);
        w_cmd.sample_time  = i_sample_time;
        w_cmd.sample_value = i_sample_value;
        w_cmd.interpolate  = i_interpolate;
        w_cmd.entry_index  = i_entry_index;
        w_cmd.skew_amount  = i_skew_amount;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

[design/tsit_back.sv]
// Back end: sample store, binary search, serial interpolation divide and result register.
module tsit_back import tsit_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_ready,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [WORD_W-1:0] r_min, n_min, r_max, n_max, r_off, n_off;
    logic [WORD_W-1:0] r_first_raw, n_first_raw, r_last_raw, n_last_raw;
    logic [WORD_W-1:0] r_q, n_q, r_t0, n_t0, r_v0, n_v0;
    logic              r_interp, n_interp;
    logic [AW-1:0]     r_lo, n_lo, r_hi, n_hi, r_raddr, n_raddr;
    logic [WORD_W-1:0] r_span, n_span, r_dt, n_dt, r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [WORD_W-1:0] r_rem, n_rem, r_dlo, n_dlo, r_quo, n_quo;
    logic [4:0]        r_step, n_step;
    logic              r_acc, n_acc;
    logic [WORD_W-1:0] r_res_v, n_res_v, r_res_t, n_res_t;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wtime;
    logic [WORD_W-1:0] rd_t, rd_v;
    logic [WORD_W-1:0] w_tm, w_first_t, w_last_t, w_new_raw;
    logic [AW-1:0]     w_lo, w_hi, w_mid;
    logic [32:0]       w_span, w_dt, w_dv, w_rem2;
    logic [63:0]       w_prod;
    logic [33:0]       w_base;

    tsit_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wtime),
        .i_raddr(r_raddr),
        .o_rdata(rd_t)
    );

    tsit_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_cmd.sample_value),
        .i_raddr(r_raddr),
        .o_rdata(rd_v)
    );

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    assign w_tm      = rd_t + r_off;
    assign w_first_t = r_first_raw + r_off;
    assign w_last_t  = r_last_raw + r_off;
    assign w_new_raw = i_cmd.sample_time - r_off;
    assign w_waddr   = r_count[AW-1:0];
    assign w_wtime   = w_new_raw;
    assign w_span    = {w_tm[31], w_tm} - {r_t0[31], r_t0};
    assign w_dt      = {r_q[31], r_q} - {r_t0[31], r_t0};
    assign w_dv      = {rd_v[31], rd_v} - {r_v0[31], r_v0};
    assign w_prod    = r_dt * r_mag;
    assign w_rem2    = {r_rem, r_dlo[31]};
    assign w_base    = r_neg ? ({{2{r_v0[31]}}, r_v0} - {2'b00, r_quo})
                             : ({{2{r_v0[31]}}, r_v0} + {2'b00, r_quo});

    always_comb begin
        if ($signed(w_tm) <= $signed(r_q)) begin
            w_lo = r_raddr;
            w_hi = r_hi;
        end else begin
            w_lo = r_lo;
            w_hi = r_raddr;
        end
        w_mid = w_lo + ((w_hi - w_lo) >> 1);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_off       = r_off;
        n_first_raw = r_first_raw;
        n_last_raw  = r_last_raw;
        n_q         = r_q;
        n_t0        = r_t0;
        n_v0        = r_v0;
        n_interp    = r_interp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_raddr     = r_raddr;
        n_span      = r_span;
        n_dt        = r_dt;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_dlo       = r_dlo;
        n_quo       = r_quo;
        n_step      = r_step;
        n_acc       = r_acc;
        n_res_v     = r_res_v;
        n_res_t     = r_res_t;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        w_we        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_acc    = 1'b0;
                    n_res_v  = '0;
                    n_res_t  = '0;
                    n_q      = i_cmd.sample_time;
                    n_interp = i_cmd.interpolate;
                    n_state  = ST_DONE;
                    case (i_cmd.op)
                        OP_APPEND: begin
                            if (r_count < CW'(DEPTH) && (r_count == '0 ||
                                $signed(w_last_t) <= $signed(i_cmd.sample_time))) begin
                                w_we       = 1'b1;
                                n_acc      = 1'b1;
                                n_count    = r_count + 1'b1;
                                n_last_raw = w_new_raw;
                                if (r_count == '0) begin
                                    n_first_raw = w_new_raw;
                                end
                                if (r_count == '0 ||
                                    $signed(i_cmd.sample_value) > $signed(r_max)) begin
                                    n_max = i_cmd.sample_value;
                                end
                                if (r_count == '0 ||
                                    $signed(i_cmd.sample_value) < $signed(r_min)) begin
                                    n_min = i_cmd.sample_value;
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_count == '0) begin
                                n_state = ST_DONE;
                            end else if ($signed(i_cmd.sample_time) >= $signed(w_last_t)) begin
                                n_raddr = AW'(r_count - 1'b1);
                                n_state = ST_VAL_RD;
                            end else if ($signed(i_cmd.sample_time) <= $signed(w_first_t)) begin
                                n_raddr = '0;
                                n_state = ST_VAL_RD;
                            end else begin
                                n_lo = '0;
                                n_hi = AW'(r_count - 1'b1);
                                if (AW'(r_count - 1'b1) > AW'(1)) begin
                                    n_raddr = AW'((r_count - 1'b1) >> 1);
                                    n_state = ST_SEARCH_RD;
                                end else begin
                                    n_raddr = '0;
                                    n_state = ST_LO_RD;
                                end
                            end
                        end
                        OP_INDEX: begin
                            if (32'(i_cmd.entry_index) < 32'(r_count)) begin
                                n_raddr = AW'(i_cmd.entry_index);
                                n_state = ST_IDX_RD;
                            end
                        end
                        OP_SKEW: begin
                            n_off = r_off + i_cmd.skew_amount;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_VAL_RD: n_state = ST_VAL_USE;
            ST_VAL_USE: begin
                n_res_v = rd_v;
                n_state = ST_DONE;
            end
            ST_IDX_RD: n_state = ST_IDX_USE;
            ST_IDX_USE: begin
                n_res_v = rd_v;
                n_res_t = w_tm;
                n_state = ST_DONE;
            end
            ST_SEARCH_RD: n_state = ST_SEARCH_USE;
            ST_SEARCH_USE: begin
                n_lo = w_lo;
                n_hi = w_hi;
                if (w_hi - w_lo > AW'(1)) begin
                    n_raddr = w_mid;
                    n_state = ST_SEARCH_RD;
                end else begin
                    n_raddr = w_lo;
                    n_state = ST_LO_RD;
                end
            end
            ST_LO_RD: n_state = ST_LO_USE;
            ST_LO_USE: begin
                n_t0 = w_tm;
                n_v0 = rd_v;
                if (w_tm == r_q || !r_interp) begin
                    n_res_v = rd_v;
                    n_state = ST_DONE;
                end else begin
                    n_raddr = r_hi;
                    n_state = ST_HI_RD;
                end
            end
            ST_HI_RD: n_state = ST_HI_USE;
            ST_HI_USE: begin
                if (w_span[32] || w_span == '0) begin
                    n_res_v = r_v0;
                    n_state = ST_DONE;
                end else begin
                    n_span  = w_span[31:0];
                    n_dt    = w_dt[31:0];
                    n_neg   = w_dv[32];
                    n_mag   = w_dv[32] ? 32'(-w_dv) : w_dv[31:0];
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_rem   = w_prod[63:32];
                n_dlo   = w_prod[31:0];
                n_quo   = '0;
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_rem2 >= {1'b0, r_span}) begin
                    n_rem = 32'(w_rem2 - {1'b0, r_span});
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = w_rem2[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_dlo  = {r_dlo[30:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == 5'd31) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                n_res_v = w_base[31:0];
                if (r_rem != '0) begin
                    if (!r_neg && w_base[33]) begin
                        n_res_v = 32'(w_base + 34'd1);
                    end else if (r_neg && !w_base[33] && w_base != '0) begin
                        n_res_v = 32'(w_base - 34'd1);
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid          = 1'b1;
                    n_out.accepted       = r_acc;
                    n_out.result_value   = r_res_v;
                    n_out.result_time    = r_res_t;
                    n_out.entry_count    = COUNT_W'(r_count);
                    n_out.min_value      = r_min;
                    n_out.max_value      = r_max;
                    n_out.first_time     = (r_count != '0) ? w_first_t : '0;
                    n_out.last_time      = (r_count != '0) ? w_last_t : '0;
                    n_state              = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_raw <= n_first_raw;
        r_last_raw  <= n_last_raw;
        r_q         <= n_q;
        r_t0        <= n_t0;
        r_v0        <= n_v0;
        r_interp    <= n_interp;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_raddr     <= n_raddr;
        r_span      <= n_span;
        r_dt        <= n_dt;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_rem       <= n_rem;
        r_dlo       <= n_dlo;
        r_quo       <= n_quo;
        r_step      <= n_step;
        r_acc       <= n_acc;
        r_res_v     <= n_res_v;
        r_res_t     <= n_res_t;
        r_out       <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("stored count beyond depth");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $signed(r_min) <= $signed(r_max))
        else $error("running minimum above maximum");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH_USE) |-> (r_lo < r_raddr && r_raddr < r_hi))
        else $error("search probe outside bracket");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == $past(r_count) + 1'b1 && r_acc))
        else $error("store write without count advance");

endmodule

[design/time_series_interp_table.sv]
// Time series store with clamped, optionally interpolated lookup by time.
// Append, skew and lookups in an empty store finish without a store read; index and clamped
// lookups read one entry; an in-range lookup runs a binary search of read and use probes,
// then reads the lower entry; interpolation also reads the upper one, multiplies and divides.
// The back end holds one item at a time; a two-item queue takes items meanwhile.
// Synchronous active-low reset empties the store and clears min, max and skew.
module time_series_interp_table import tsit_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_mode,
    input  logic [WORD_W-1:0]  i_sample_time,
    input  logic [WORD_W-1:0]  i_sample_value,
    input  logic               i_interpolate,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [WORD_W-1:0]  i_skew_amount,
    output logic               empty,
    input  logic               pop,
    output logic               o_accepted,
    output logic [WORD_W-1:0]  o_result_value,
    output logic [WORD_W-1:0]  o_result_time,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic [WORD_W-1:0]  o_min_value,
    output logic [WORD_W-1:0]  o_max_value,
    output logic [WORD_W-1:0]  o_first_time,
    output logic [WORD_W-1:0]  o_last_time
);

    logic    w_cmd_valid, w_cmd_ready;
    t_cmd    w_cmd;
    t_result w_res;

    tsit_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_mode        (i_mode),
        .i_sample_time (i_sample_time),
        .i_sample_value(i_sample_value),
        .i_interpolate (i_interpolate),
        .i_entry_index (i_entry_index),
        .i_skew_amount (i_skew_amount),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_ready   (w_cmd_ready)
    );

    tsit_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_ready(w_cmd_ready),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (w_res)
    );

    assign o_accepted     = w_res.accepted;
    assign o_result_value = w_res.result_value;
    assign o_result_time  = w_res.result_time;
    assign o_entry_count  = w_res.entry_count;
    assign o_min_value    = w_res.min_value;
    assign o_max_value    = w_res.max_value;
    assign o_first_time   = w_res.first_time;
    assign o_last_time    = w_res.last_time;

endmodule
